// File: rtl/core/clrt_pkg.sv
// shared types, constants and register codes of the climb leg retract trigger
package clrt_pkg;

  localparam int DIST_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  localparam int ALPHA_W  = 16;
  localparam int THR_W    = 16;
  localparam int VLIM_W   = 15;
  localparam int HOLD_W   = 16;
  localparam int CNT_W    = 16;
  localparam int DIN_W    = 16;
  localparam int VEL_W    = 16;
  localparam int DOUT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd16384;
  localparam logic [THR_W-1:0]   DIST_HIGH_RST = 16'd200;
  localparam logic [THR_W-1:0]   DIST_LOW_RST  = 16'd100;
  localparam logic [VLIM_W-1:0]  VEL_BACK_RST  = 15'd100;
  localparam logic [VLIM_W-1:0]  VEL_FRONT_RST = 15'd100;
  localparam logic [HOLD_W-1:0]  HOLD_RST      = 16'd50;
  localparam logic [CNT_W-1:0]   CNT_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ALPHA    = 3'd0,
    REG_DIST_HIGH       = 3'd1,
    REG_DIST_LOW        = 3'd2,
    REG_VEL_BACK_LIMIT  = 3'd3,
    REG_VEL_FRONT_LIMIT = 3'd4,
    REG_HOLD_TICKS      = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    REQ_ENTER = 1'b0,
    REQ_STEP  = 1'b1
  } req_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] filter_alpha;
    logic [THR_W-1:0]   dist_high;
    logic [THR_W-1:0]   dist_low;
    logic [VLIM_W-1:0]  vel_back_limit;
    logic [VLIM_W-1:0]  vel_front_limit;
    logic [HOLD_W-1:0]  hold_ticks;
  } clrt_cfg_t;

  typedef struct packed {
    logic             suspended;
    logic             latch;
    logic [CNT_W-1:0] low_cnt;
  } clrt_flags_t;

endpackage

// File: rtl/core/clrt_if.sv
// valid/ready channel interfaces for input, result and configuration transactions
interface clrt_in_if;
  import clrt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [DIN_W-1:0]        ground_mm;
  logic signed [VEL_W-1:0] velocity_x;
  logic                    manual_retract;
  modport source (output valid, req_type, ground_mm, velocity_x, manual_retract,
                  input ready);
  modport sink (input valid, req_type, ground_mm, velocity_x, manual_retract,
                output ready);
endinterface

interface clrt_out_if;
  import clrt_pkg::*;
  logic              valid;
  logic              ready;
  logic              retract_legs;
  logic              auto_retract;
  logic              wheel_suspended;
  logic [DOUT_W-1:0] smoothed_distance;
  modport source (output valid, retract_legs, auto_retract, wheel_suspended,
                  smoothed_distance, input ready);
  modport sink (input valid, retract_legs, auto_retract, wheel_suspended,
                smoothed_distance, output ready);
endinterface

interface clrt_cfg_if;
  import clrt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/clrt_filter.sv
// first-order low-pass update of the filtered distance, one multiply
module clrt_filter
  import clrt_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [ALPHA_W-1:0]             alpha,
  input  logic [DIST_BITS+FRAC_BITS-1:0] sample,
  input  logic [DIST_BITS+FRAC_BITS-1:0] f_cur,
  output logic [DIST_BITS+FRAC_BITS-1:0] f_nxt
);

  localparam int FV_W   = DIST_BITS + FRAC_BITS;
  localparam int DIFF_W = FV_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int ACC_W  = FV_W + ALPHA_W + 2;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ALPHA_W - 1);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc;

  // f + alpha*(s - f) equals alpha*s + (1 - alpha)*f
  always_comb begin
    diff  = $signed({1'b0, sample}) - $signed({1'b0, f_cur});
    prod  = $signed({1'b0, alpha}) * diff;
    acc   = (ACC_W'(f_cur) << ALPHA_W) + ACC_W'(prod) + ROUND_HALF;
    f_nxt = acc[ALPHA_W +: FV_W];
  end

endmodule

// File: rtl/core/clrt_decide.sv
// suspension, auto retract latch and low tick counter update for one step
module clrt_decide
  import clrt_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  clrt_cfg_t                      cfg,
  input  logic [DIST_BITS+FRAC_BITS-1:0] f_new,
  input  logic signed [VEL_W-1:0]        velocity_x,
  input  clrt_flags_t                    flags_cur,
  output clrt_flags_t                    flags_nxt
);

  localparam int FV_W = DIST_BITS + FRAC_BITS;
  localparam int CW   = FV_W + THR_W;

  logic [CW-1:0]           f_ext;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           lo;
  logic signed [VEL_W:0]   vx_e;
  logic signed [VEL_W:0]   vbl_e;
  logic signed [VEL_W:0]   vfl_e;
  logic                    moving_back;
  logic                    moving_fwd;
  logic [CNT_W-1:0]        cnt_inc;
  clrt_flags_t             fl;

  always_comb begin
    f_ext       = CW'(f_new);
    hi          = CW'(cfg.dist_high) << FRAC_BITS;
    lo          = CW'(cfg.dist_low) << FRAC_BITS;
    vx_e        = {velocity_x[VEL_W-1], velocity_x};
    vbl_e       = {2'b00, cfg.vel_back_limit};
    vfl_e       = {2'b00, cfg.vel_front_limit};
    moving_back = vx_e < -vbl_e;
    moving_fwd  = vx_e > vfl_e;
    fl          = flags_cur;
    cnt_inc     = '0;
    if (f_ext > hi) begin
      fl.suspended = 1'b1;
      fl.low_cnt   = '0;
    end else if (f_ext < lo) begin
      if (fl.suspended && moving_back) begin
        fl.suspended = 1'b0;
      end else if (fl.suspended && moving_fwd) begin
        fl.latch     = 1'b1;
        fl.suspended = 1'b0;
        fl.low_cnt   = '0;
      end
      if (fl.latch) begin
        cnt_inc = (fl.low_cnt != CNT_MAX) ? fl.low_cnt + CNT_W'(1) : fl.low_cnt;
        if (cnt_inc >= cfg.hold_ticks) begin
          fl.latch   = 1'b0;
          fl.low_cnt = '0;
        end else begin
          fl.low_cnt = cnt_inc;
        end
      end
    end else if (fl.latch) begin
      fl.low_cnt = '0;
    end
    flags_nxt = fl;
  end

endmodule

// File: rtl/core/climb_leg_retract_trigger_core.sv
// top level: input register, filter and flag update, result register, config registers
// Accepts one transaction per clock while the result channel is not stalled; a result
// passes the input register, then the result register. The filter multiply and the
// threshold and velocity compares run between those registers and write the
// filter and flag state in the same edge, so the next item sees it at once. An enter
// transaction reloads the filter and clears the flags and produces no result; a step
// transaction produces exactly one result. Configuration writes are always taken.
module climb_leg_retract_trigger_core
  import clrt_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  clrt_in_if.sink  in_ch,
  clrt_out_if.source out_ch,
  clrt_cfg_if.sink cfg_ch
);

  localparam int FV_W = DIST_BITS + FRAC_BITS;

  clrt_cfg_t               cfg_r;
  logic                    s1_valid_r;
  logic                    s1_req_r;
  logic [DIN_W-1:0]        s1_dist_r;
  logic signed [VEL_W-1:0] s1_vel_r;
  logic                    s1_manual_r;
  logic [FV_W-1:0]         f_r;
  clrt_flags_t             flags_r;
  logic                    out_valid_r;
  logic                    out_retract_r;
  logic                    out_auto_r;
  logic                    out_susp_r;
  logic [DOUT_W-1:0]       out_dist_r;

  logic [DIST_BITS-1:0]    dist_s1;
  logic [FV_W-1:0]         sample;
  logic [FV_W-1:0]         f_step;
  clrt_flags_t             flags_step;
  logic                    out_free;
  logic                    s1_fire;
  logic                    in_acc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_alpha    <= ALPHA_RST;
      cfg_r.dist_high       <= DIST_HIGH_RST;
      cfg_r.dist_low        <= DIST_LOW_RST;
      cfg_r.vel_back_limit  <= VEL_BACK_RST;
      cfg_r.vel_front_limit <= VEL_FRONT_RST;
      cfg_r.hold_ticks      <= HOLD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.reg_index))
        REG_FILTER_ALPHA:    cfg_r.filter_alpha    <= cfg_ch.wdata[ALPHA_W-1:0];
        REG_DIST_HIGH:       cfg_r.dist_high       <= cfg_ch.wdata[THR_W-1:0];
        REG_DIST_LOW:        cfg_r.dist_low        <= cfg_ch.wdata[THR_W-1:0];
        REG_VEL_BACK_LIMIT:  cfg_r.vel_back_limit  <= cfg_ch.wdata[VLIM_W-1:0];
        REG_VEL_FRONT_LIMIT: cfg_r.vel_front_limit <= cfg_ch.wdata[VLIM_W-1:0];
        REG_HOLD_TICKS:      cfg_r.hold_ticks      <= cfg_ch.wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: enter items need no result slot
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && ((s1_req_r == REQ_ENTER) || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r    <= in_ch.req_type;
      s1_dist_r   <= in_ch.ground_mm;
      s1_vel_r    <= in_ch.velocity_x;
      s1_manual_r <= in_ch.manual_retract;
    end
  end

  assign dist_s1 = DIST_BITS'(s1_dist_r);
  assign sample  = FV_W'(dist_s1) << FRAC_BITS;

  clrt_filter #(
    .DIST_BITS (DIST_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_filter (
    .alpha  (cfg_r.filter_alpha),
    .sample (sample),
    .f_cur  (f_r),
    .f_nxt  (f_step)
  );

  clrt_decide #(
    .DIST_BITS (DIST_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_decide (
    .cfg        (cfg_r),
    .f_new      (f_step),
    .velocity_x (s1_vel_r),
    .flags_cur  (flags_r),
    .flags_nxt  (flags_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r     <= '0;
      flags_r <= '0;
    end else if (s1_fire) begin
      if (s1_req_r == REQ_ENTER) begin
        f_r     <= sample;
        flags_r <= '0;
      end else begin
        f_r     <= f_step;
        flags_r <= flags_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && (s1_req_r == REQ_STEP)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_req_r == REQ_STEP)) begin
      out_retract_r <= s1_manual_r | flags_step.latch;
      out_auto_r    <= flags_step.latch;
      out_susp_r    <= flags_step.suspended;
      out_dist_r    <= DOUT_W'(f_step >> FRAC_BITS);
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.retract_legs      = out_retract_r;
  assign out_ch.auto_retract      = out_auto_r;
  assign out_ch.wheel_suspended   = out_susp_r;
  assign out_ch.smoothed_distance = out_dist_r;

endmodule

// File: rtl/core/clrt_checker.sv
// port-level checker for the climb leg retract trigger and its bind
module clrt_checker
  import clrt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              retract_legs,
  input logic              auto_retract,
  input logic              wheel_suspended,
  input logic [DOUT_W-1:0] smoothed_distance
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(retract_legs) && $stable(auto_retract)
      && $stable(wheel_suspended) && $stable(smoothed_distance))
    else $error("result payload changed while stalled");

  // auto retract always selects leg retraction
  a_auto_selects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && auto_retract |-> retract_legs)
    else $error("auto retract without retract selection");

endmodule

bind climb_leg_retract_trigger_core clrt_checker u_clrt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .retract_legs      (out_ch.retract_legs),
  .auto_retract      (out_ch.auto_retract),
  .wheel_suspended   (out_ch.wheel_suspended),
  .smoothed_distance (out_ch.smoothed_distance)
);

// File: verif/climb_leg_retract_trigger_core_tb.sv
// self-checking testbench of climb_leg_retract_trigger_core: directed table, then random episodes
`timescale 1ns / 1ps

module climb_leg_retract_trigger_core_tb;
  import clrt_pkg::*;

  localparam int FV_W = DIST_BITS_DEF + FRAC_BITS_DEF;
  localparam int DIR_ROWS = 22;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 222;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic              retract_legs;
    logic              auto_retract;
    logic              wheel_suspended;
    logic [DOUT_W-1:0] smoothed_distance;
  } retract_res_t;

  typedef struct packed {
    bit           typed;
    retract_res_t res;
  } typed_res_t;

  typedef struct packed {
    req_t                    req;
    logic [DIN_W-1:0]        gnd;
    logic signed [VEL_W-1:0] vel;
    logic                    man;
    bit                      typed;
    retract_res_t            res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  clrt_in_if  in_ch();
  clrt_out_if out_ch();
  clrt_cfg_if cfg_ch();

  climb_leg_retract_trigger_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow registers and state of the trigger
  clrt_cfg_t shadow_cfg = '{filter_alpha: ALPHA_RST, dist_high: DIST_HIGH_RST,
                            dist_low: DIST_LOW_RST, vel_back_limit: VEL_BACK_RST,
                            vel_front_limit: VEL_FRONT_RST, hold_ticks: HOLD_RST};
  clrt_flags_t     trig_flags = '0;
  logic [FV_W-1:0] filt_val = '0;

  retract_res_t expected_res_q[$];
  typed_res_t   typed_q[$];
  retract_res_t want;
  retract_res_t predicted;

  int err_count = 0;
  int items_sent = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 17;
  int rx_idle_pct = 79;
  int hold_off_cycles = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},
    '{REQ_STEP,  16'd0,     16'sh8000,   1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 16'd0}},
    '{REQ_ENTER, 16'hFFFF,  16'sd0,      1'b1, 1'b0, '0},
    '{REQ_STEP,  16'hFFFF,  16'sh7FFF,   1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 16'hFFFF}},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_ENTER, 16'd300,   16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd300,   16'sd0,      1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 16'd300}},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd101,    1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     -16'sd101,   1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd150,   16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b1, 1'b0, '0},
    '{REQ_ENTER, 16'd300,   16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd300,   16'sd0,      1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 16'd300}},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd0,      1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     16'sd100,    1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     -16'sd100,   1'b0, 1'b0, '0},
    '{REQ_STEP,  16'd0,     -16'sd101,   1'b0, 1'b0, '0}
  };

  function automatic bit predict_trigger(input req_t req, input logic [DIN_W-1:0] gnd,
                                         input logic signed [VEL_W-1:0] vel, input logic man,
                                         output retract_res_t res);
    logic [FV_W-1:0] sample;
    logic [47:0]     acc;
    logic [31:0]     hi_thr;
    logic [31:0]     lo_thr;
    int              vx;
    sample = FV_W'(gnd) << FRAC_BITS_DEF;
    vx = vel;
    res = '0;
    if (req == REQ_ENTER) begin
      filt_val = sample;
      trig_flags = '0;
      return 1'b0;
    end
    acc = 48'(shadow_cfg.filter_alpha) * 48'(sample)
        + (48'd65536 - 48'(shadow_cfg.filter_alpha)) * 48'(filt_val) + 48'd32768;
    filt_val = acc[16 +: FV_W];
    hi_thr = 32'(shadow_cfg.dist_high) << FRAC_BITS_DEF;
    lo_thr = 32'(shadow_cfg.dist_low) << FRAC_BITS_DEF;
    if (32'(filt_val) > hi_thr) begin
      trig_flags.suspended = 1'b1;
      trig_flags.low_cnt = '0;
    end else if (32'(filt_val) < lo_thr) begin
      if (trig_flags.suspended && vx < -int'(shadow_cfg.vel_back_limit)) begin
        trig_flags.suspended = 1'b0;
      end else if (trig_flags.suspended && vx > int'(shadow_cfg.vel_front_limit)) begin
        trig_flags.latch = 1'b1;
        trig_flags.suspended = 1'b0;
        trig_flags.low_cnt = '0;
      end
      if (trig_flags.latch) begin
        if (trig_flags.low_cnt != CNT_MAX) trig_flags.low_cnt++;
        if (trig_flags.low_cnt >= shadow_cfg.hold_ticks) begin
          trig_flags.latch = 1'b0;
          trig_flags.low_cnt = '0;
        end
      end
    end else if (trig_flags.latch) begin
      trig_flags.low_cnt = '0;
    end
    res.retract_legs = man | trig_flags.latch;
    res.auto_retract = trig_flags.latch;
    res.wheel_suspended = trig_flags.suspended;
    res.smoothed_distance = filt_val[FRAC_BITS_DEF +: DOUT_W];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    if (err_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, wanted);
    err_count++;
  endtask

  // register writes and input transactions as the block takes them
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.reg_index))
        REG_FILTER_ALPHA:    shadow_cfg.filter_alpha = cfg_ch.wdata;
        REG_DIST_HIGH:       shadow_cfg.dist_high = cfg_ch.wdata;
        REG_DIST_LOW:        shadow_cfg.dist_low = cfg_ch.wdata;
        REG_VEL_BACK_LIMIT:  shadow_cfg.vel_back_limit = cfg_ch.wdata[VLIM_W-1:0];
        REG_VEL_FRONT_LIMIT: shadow_cfg.vel_front_limit = cfg_ch.wdata[VLIM_W-1:0];
        REG_HOLD_TICKS:      shadow_cfg.hold_ticks = cfg_ch.wdata;
        default: ;
      endcase
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      typed_res_t entry;
      entry = typed_q.pop_front();
      if (predict_trigger(req_t'(in_ch.req_type), in_ch.ground_mm, in_ch.velocity_x,
                          in_ch.manual_retract, predicted))
        expected_res_q.push_back(entry.typed ? entry.res : predicted);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_res_q.size() == 0) begin
        report_mismatch("result with nothing expected, smoothed_distance",
                        out_ch.smoothed_distance, '0);
      end else begin
        want = expected_res_q.pop_front();
        if (out_ch.retract_legs !== want.retract_legs)
          report_mismatch("retract_legs", out_ch.retract_legs, want.retract_legs);
        if (out_ch.auto_retract !== want.auto_retract)
          report_mismatch("auto_retract", out_ch.auto_retract, want.auto_retract);
        if (out_ch.wheel_suspended !== want.wheel_suspended)
          report_mismatch("wheel_suspended", out_ch.wheel_suspended, want.wheel_suspended);
        if (out_ch.smoothed_distance !== want.smoothed_distance)
          report_mismatch("smoothed_distance", out_ch.smoothed_distance,
                          want.smoothed_distance);
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** climb_leg_retract_trigger_core: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input req_t req, input logic [DIN_W-1:0] gnd,
                           input logic signed [VEL_W-1:0] vel, input logic man,
                           input bit typed, input retract_res_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.ground_mm <= gnd;
    in_ch.velocity_x <= vel;
    in_ch.manual_retract <= man;
    typed_q.push_back('{typed, res});
    items_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic step_item(input logic [DIN_W-1:0] gnd, input logic signed [VEL_W-1:0] vel);
    send_item(REQ_STEP, gnd, vel, 1'($urandom), 1'b0, '0);
  endtask

  function automatic logic [DIN_W-1:0] dist_above();
    if (shadow_cfg.dist_high == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(65535, 32'(shadow_cfg.dist_high) + 1));
  endfunction

  function automatic logic [DIN_W-1:0] dist_below();
    if (shadow_cfg.dist_low == 16'd0) return 16'd0;
    return 16'($urandom_range(32'(shadow_cfg.dist_low) - 1, 0));
  endfunction

  // enter, climb above the high threshold, drop below the low one, then a run of low ticks
  task automatic run_episode();
    int rise_n;
    int fall_n;
    int run_n;
    int hold_cap;
    logic signed [VEL_W-1:0] v;
    send_item(REQ_ENTER, $urandom_range(1) ? dist_above() : 16'($urandom), 16'($urandom),
              1'($urandom), 1'b0, '0);
    rise_n = $urandom_range(6, 1);
    repeat (rise_n) step_item(dist_above(), 16'($urandom));
    fall_n = $urandom_range(8, 1);
    repeat (fall_n) begin
      case ($urandom_range(3))
        0, 1: v = (shadow_cfg.vel_front_limit == 15'h7FFF) ? 16'sh7FFF :
                  16'($urandom_range(32767, 32'(shadow_cfg.vel_front_limit) + 1));
        2: v = -16'($urandom_range(32768, 32'(shadow_cfg.vel_back_limit) + 1));
        default: v = 16'($urandom);
      endcase
      step_item(dist_below(), v);
    end
    hold_cap = (shadow_cfg.hold_ticks > 60) ? 60 : int'(shadow_cfg.hold_ticks);
    run_n = $urandom_range(hold_cap + 3, 0);
    repeat (run_n)
      step_item(($urandom_range(9) == 0) ? 16'($urandom) : dist_below(), 16'($urandom));
  endtask

  task automatic program_regs(input int phase);
    logic [CFG_DATA_W-1:0] plan [2**CFG_IDX_W];
    foreach (plan[i]) plan[i] = 16'($urandom);
    case (phase)
      0: begin
        plan[REG_FILTER_ALPHA] = 16'($urandom_range(65535, 16384));
        plan[REG_DIST_HIGH] = 16'($urandom_range(400, 150));
        plan[REG_DIST_LOW] = 16'($urandom_range(150, 50));
        plan[REG_VEL_BACK_LIMIT] = 16'($urandom_range(300, 0));
        plan[REG_VEL_FRONT_LIMIT] = 16'($urandom_range(300, 0));
        plan[REG_HOLD_TICKS] = 16'($urandom_range(20, 0));
      end
      1: begin
        plan[REG_FILTER_ALPHA] = 16'hFFFF;
        plan[REG_DIST_HIGH] = 16'hFFFF;
        plan[REG_DIST_LOW] = 16'hFFFF;
        plan[REG_VEL_BACK_LIMIT] = 16'hFFFF;
        plan[REG_VEL_FRONT_LIMIT] = 16'hFFFF;
        plan[REG_HOLD_TICKS] = 16'hFFFF;
      end
      2: begin
        // low threshold above the high one
        plan[REG_FILTER_ALPHA] = 16'($urandom_range(65535, 32768));
        plan[REG_DIST_HIGH] = 16'($urandom_range(300, 100));
        plan[REG_DIST_LOW] = plan[REG_DIST_HIGH] + 16'($urandom_range(200, 1));
        plan[REG_VEL_BACK_LIMIT] = 16'($urandom_range(1000, 0));
        plan[REG_VEL_FRONT_LIMIT] = 16'($urandom_range(1000, 0));
        plan[REG_HOLD_TICKS] = 16'($urandom_range(3, 0));
      end
      3: begin
        plan[REG_FILTER_ALPHA] = 16'd0;
        plan[REG_DIST_HIGH] = 16'd0;
        plan[REG_DIST_LOW] = 16'd0;
        plan[REG_VEL_BACK_LIMIT] = 16'd0;
        plan[REG_VEL_FRONT_LIMIT] = 16'd0;
        plan[REG_HOLD_TICKS] = 16'd0;
      end
      4: begin
        plan[REG_FILTER_ALPHA] = 16'($urandom_range(65535, 30000));
        plan[REG_DIST_HIGH] = 16'($urandom_range(5000, 500));
        plan[REG_DIST_LOW] = 16'($urandom_range(400, 10));
        plan[REG_HOLD_TICKS] = 16'($urandom_range(60, 20));
      end
      default: begin
        // short hold after a long one releases a pending latch early
        plan[REG_HOLD_TICKS] = 16'($urandom_range(8, 0));
      end
    endcase
    foreach (plan[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.reg_index <= CFG_IDX_W'(i);
      cfg_ch.wdata <= plan[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_res_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ENTER;
    in_ch.ground_mm = '0;
    in_ch.velocity_x = '0;
    in_ch.manual_retract = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_FILTER_ALPHA;
    cfg_ch.wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].gnd, dir_rows[i].vel, dir_rows[i].man,
                dir_rows[i].typed, dir_rows[i].res);
    in_ch.valid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      tx_idle_pct = (phase < 2) ? 17 : (phase < 4) ? 79 : 0;
      rx_idle_pct = (phase < 2) ? 79 : (phase < 4) ? 17 : 0;
      program_regs(phase);
      if (phase == 4) hold_off_cycles = 48;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(8, 1))
            send_item(($urandom_range(9) == 0) ? REQ_ENTER : REQ_STEP, 16'($urandom),
                      16'($urandom), 1'($urandom), 1'b0, '0);
        end else begin
          run_episode();
        end
      end
      in_ch.valid <= 1'b0;
    end

    wait_drained();
    if (err_count == 0) begin
      $display("** climb_leg_retract_trigger_core: PASSED **");
    end else begin
      $display("** climb_leg_retract_trigger_core: FAILED **");
    end
    $finish;
  end

endmodule
